@@ sv/triangle_unit_normal_unit_defines.svh @@
// Assertion macros shared by the triangle normal unit.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH

// Expression holds at every clock edge outside reset.
`define TUN_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("tun assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tun assertion failed");

`endif

@@ sv/tun_pkg.sv @@
// Types, widths and helpers for the triangle normal unit.
// Used by every module of the block; no dependencies.
package tun_pkg;

  localparam int CoordBits = 16;
  localparam int FieldW    = 16;
  localparam int CoordW    = (CoordBits < FieldW) ? CoordBits : FieldW;
  localparam int EdgeW     = CoordW + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int CrossW    = ProdW + 1;
  // Magnitudes are brought below 2^30 before squaring.
  localparam int MagW      = 30;
  localparam int MagXW     = CrossW + MagW;
  localparam int ShMax     = (CrossW > MagW) ? (CrossW - MagW) : 0;
  localparam int ShW       = $clog2(ShMax + 2);
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 2;
  localparam int SqIt      = SumW / 2;
  localparam int SqWork    = SumW + 1;
  localparam int RootW     = SqIt;
  localparam int NormShift = 15;
  localparam int QW        = NormShift + 1;
  localparam int RemW      = RootW + NormShift + 1;
  localparam int OutW      = 16;
  localparam logic [QW-1:0] NormMax = QW'(32767);

  // One item as it travels from the front part to the back part.
  typedef struct packed {
    logic [SumW-1:0]        sum;
    logic [2:0][MagW-1:0]   mag;
    logic [2:0]             neg;
    logic                   deg;
  } tun_item_t;

  // Per-item data carried along the back pipeline.
  typedef struct packed {
    logic [2:0][MagW-1:0]   mag;
    logic [2:0]             neg;
    logic                   deg;
  } tun_meta_t;

  // Low coordinate bits of a field, read as signed.
  function automatic logic signed [CoordW-1:0] coord_of(input logic [FieldW-1:0] raw);
    coord_of = $signed(raw[CoordW-1:0]);
  endfunction

endpackage

@@ sv/tun_front.sv @@
// Front part: edges, cross product, range reduction and sum of squares.
// Depends on tun_pkg.
module tun_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [9*tun_pkg::FieldW-1:0] in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tun_pkg::tun_item_t          out_item_o
);

  localparam int NS = 6;

  logic [NS-1:0] vld_q;
  logic          en;

  logic signed [tun_pkg::EdgeW-1:0]  e_q [3];
  logic signed [tun_pkg::EdgeW-1:0]  d_q [3];
  logic signed [tun_pkg::ProdW-1:0]  p_q [6];
  logic [tun_pkg::CrossW-1:0]        cm_q [3];
  logic [2:0]                        neg3_q, neg4_q, neg5_q, neg6_q;
  logic                              deg3_q, deg4_q, deg5_q, deg6_q;
  logic [tun_pkg::MagW-1:0]          m4_q [3];
  logic [tun_pkg::MagW-1:0]          m5_q [3];
  logic [tun_pkg::MagW-1:0]          m6_q [3];
  logic [tun_pkg::SqW-1:0]           sq_q [3];
  logic [tun_pkg::SumW-1:0]          sum_q;

  logic signed [tun_pkg::CoordW-1:0] va [3];
  logic signed [tun_pkg::CoordW-1:0] vb [3];
  logic signed [tun_pkg::CoordW-1:0] vc [3];
  logic signed [tun_pkg::CrossW-1:0] c [3];
  logic [tun_pkg::CrossW-1:0]        or_mag;
  logic [tun_pkg::MagXW-1:0]         or_x;
  logic [tun_pkg::ShW-1:0]           sh;

  assign en         = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o = en;

  // Unpack the nine coordinates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = tun_pkg::coord_of(in_data_i[i*tun_pkg::FieldW +: tun_pkg::FieldW]);
      vb[i] = tun_pkg::coord_of(in_data_i[(3+i)*tun_pkg::FieldW +: tun_pkg::FieldW]);
      vc[i] = tun_pkg::coord_of(in_data_i[(6+i)*tun_pkg::FieldW +: tun_pkg::FieldW]);
    end
  end

  // Cross product components from the partial products.
  always_comb begin
    c[0] = tun_pkg::CrossW'(p_q[0]) - tun_pkg::CrossW'(p_q[1]);
    c[1] = tun_pkg::CrossW'(p_q[2]) - tun_pkg::CrossW'(p_q[3]);
    c[2] = tun_pkg::CrossW'(p_q[4]) - tun_pkg::CrossW'(p_q[5]);
  end

  // Smallest shift that brings the largest magnitude below 2^30.
  always_comb begin
    or_mag = cm_q[0] | cm_q[1] | cm_q[2];
    or_x   = tun_pkg::MagXW'(or_mag);
    sh     = tun_pkg::ShW'(tun_pkg::ShMax);
    for (int s = tun_pkg::ShMax; s >= 0; s--) begin
      if (((or_x >> s) >> tun_pkg::MagW) == '0) begin
        sh = tun_pkg::ShW'(s);
      end
    end
  end

  // Stage valid bits advance together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= tun_pkg::EdgeW'(vb[i]) - tun_pkg::EdgeW'(va[i]);
        d_q[i] <= tun_pkg::EdgeW'(vc[i]) - tun_pkg::EdgeW'(va[i]);
      end
      p_q[0] <= e_q[1] * d_q[2];
      p_q[1] <= e_q[2] * d_q[1];
      p_q[2] <= e_q[2] * d_q[0];
      p_q[3] <= e_q[0] * d_q[2];
      p_q[4] <= e_q[0] * d_q[1];
      p_q[5] <= e_q[1] * d_q[0];
      for (int i = 0; i < 3; i++) begin
        cm_q[i]   <= c[i][tun_pkg::CrossW-1] ? tun_pkg::CrossW'(-c[i])
                                             : tun_pkg::CrossW'(c[i]);
        neg3_q[i] <= c[i][tun_pkg::CrossW-1];
      end
      deg3_q <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
      for (int i = 0; i < 3; i++) begin
        m4_q[i] <= tun_pkg::MagW'(cm_q[i] >> sh);
        m5_q[i] <= m4_q[i];
        m6_q[i] <= m5_q[i];
        sq_q[i] <= m4_q[i] * m4_q[i];
      end
      neg4_q <= neg3_q;
      neg5_q <= neg4_q;
      neg6_q <= neg5_q;
      deg4_q <= deg3_q;
      deg5_q <= deg4_q;
      deg6_q <= deg5_q;
      sum_q  <= tun_pkg::SumW'(sq_q[0]) + tun_pkg::SumW'(sq_q[1]) + tun_pkg::SumW'(sq_q[2]);
    end
  end

  assign out_valid_o    = vld_q[NS-1];
  assign out_item_o.sum = sum_q;
  assign out_item_o.mag = {m6_q[2], m6_q[1], m6_q[0]};
  assign out_item_o.neg = neg6_q;
  assign out_item_o.deg = deg6_q;

endmodule

@@ sv/tun_fifo.sv @@
// Two-entry queue between the front and back parts.
// Depends on tun_pkg and the assertion macro header.
`include "triangle_unit_normal_unit_defines.svh"
module tun_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tun_pkg::tun_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::tun_item_t out_item_o
);

  tun_pkg::tun_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  `TUN_ASSERT(a_cnt_range, cnt_q != 2'd3)
  `TUN_ASSERT(a_ptr_match, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
  `TUN_ASSERT_NEXT(a_push_only, push && !pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

@@ sv/tun_back.sv @@
// Back part: pipelined square root, three-lane pipelined divider, saturation.
// Depends on tun_pkg and the assertion macro header.
`include "triangle_unit_normal_unit_defines.svh"
module tun_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tun_pkg::tun_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3*tun_pkg::OutW-1:0]    out_norm_o,
  output logic                          out_deg_o
);

  localparam int SqIt = tun_pkg::SqIt;
  localparam int QW   = tun_pkg::QW;
  localparam int ND   = SqIt + QW + 2;

  logic [ND-1:0]               vld_q;
  logic                        out_vld_q;
  logic                        en;
  tun_pkg::tun_meta_t          meta_q [ND];
  logic [tun_pkg::SqWork-1:0]  sv_q [SqIt+1];
  logic [tun_pkg::SqWork-1:0]  sr_q [SqIt+1];
  logic [tun_pkg::SqWork-1:0]  sv_d [SqIt+1];
  logic [tun_pkg::SqWork-1:0]  sr_d [SqIt+1];
  logic [tun_pkg::RootW-1:0]   dd_q [QW+1];
  logic [tun_pkg::RemW-1:0]    rem_q [QW+1][3];
  logic [QW-1:0]               quo_q [QW+1][3];
  logic [tun_pkg::RemW-1:0]    rem_d [QW+1][3];
  logic [QW-1:0]               quo_d [QW+1][3];
  logic [tun_pkg::RootW-1:0]   root;
  logic [tun_pkg::SqWork-1:0]  bit_v;
  logic [tun_pkg::SqWork-1:0]  trial_s;
  logic [tun_pkg::RemW-1:0]    trial_d;
  logic [QW-1:0]               sat [3];
  logic [tun_pkg::OutW-1:0]    norm_q [3];
  logic                        deg_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Square root, one result bit per stage.
  always_comb begin
    sv_d[0] = tun_pkg::SqWork'(in_item_i.sum);
    sr_d[0] = '0;
    for (int k = 0; k < SqIt; k++) begin
      bit_v   = tun_pkg::SqWork'(1) << (2 * (SqIt - 1 - k));
      trial_s = sr_q[k] + bit_v;
      if (sv_q[k] >= trial_s) begin
        sv_d[k+1] = sv_q[k] - trial_s;
        sr_d[k+1] = (sr_q[k] >> 1) + bit_v;
      end else begin
        sv_d[k+1] = sv_q[k];
        sr_d[k+1] = sr_q[k] >> 1;
      end
    end
  end

  // A zero root only comes with a degenerate item; divide by one then.
  always_comb begin
    root = sr_q[SqIt][tun_pkg::RootW-1:0];
    if (root == '0) begin
      root = tun_pkg::RootW'(1);
    end
  end

  // Restoring division, one quotient bit per stage in each lane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_d[0][i] = tun_pkg::RemW'(meta_q[SqIt].mag[i]) << tun_pkg::NormShift;
      quo_d[0][i] = '0;
    end
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial_d = tun_pkg::RemW'(dd_q[k]) << (QW - 1 - k);
        rem_d[k+1][i] = rem_q[k][i];
        quo_d[k+1][i] = quo_q[k][i];
        if (rem_q[k][i] >= trial_d) begin
          rem_d[k+1][i] = rem_q[k][i] - trial_d;
          quo_d[k+1][i] = quo_q[k][i] | (QW'(1) << (QW - 1 - k));
        end
      end
    end
  end

  // Clamp full-scale quotients.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i] = (quo_q[QW][i] > tun_pkg::NormMax) ? tun_pkg::NormMax : quo_q[QW][i];
    end
  end

  // Valid bits of all stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[ND-2:0], in_valid_i};
      out_vld_q <= vld_q[ND-1];
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0].mag <= in_item_i.mag;
      meta_q[0].neg <= in_item_i.neg;
      meta_q[0].deg <= in_item_i.deg;
      for (int k = 1; k < ND; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      for (int k = 0; k <= SqIt; k++) begin
        sv_q[k] <= sv_d[k];
        sr_q[k] <= sr_d[k];
      end
      dd_q[0] <= root;
      for (int k = 1; k <= QW; k++) begin
        dd_q[k] <= dd_q[k-1];
      end
      for (int k = 0; k <= QW; k++) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= rem_d[k][i];
          quo_q[k][i] <= quo_d[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (meta_q[ND-1].deg) begin
          norm_q[i] <= '0;
        end else if (meta_q[ND-1].neg[i]) begin
          norm_q[i] <= tun_pkg::OutW'(-sat[i]);
        end else begin
          norm_q[i] <= tun_pkg::OutW'(sat[i]);
        end
      end
      deg_q <= meta_q[ND-1].deg;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_norm_o  = {norm_q[2], norm_q[1], norm_q[0]};
  assign out_deg_o   = deg_q;

  `TUN_ASSERT(a_deg_zero, !(out_vld_q && deg_q) || (out_norm_o == '0))
  `TUN_ASSERT(a_no_min, !out_vld_q || ((norm_q[0] != 16'h8000) && (norm_q[1] != 16'h8000)
                                       && (norm_q[2] != 16'h8000)))
  `TUN_ASSERT_NEXT(a_out_hold, out_vld_q && !out_ready_i, out_vld_q && $stable(out_norm_o) && $stable(out_deg_o))

endmodule

@@ sv/triangle_unit_normal_unit.sv @@
// Top level of the triangle unit normal engine.
// Depends on tun_pkg, tun_front, tun_fifo and tun_back.
//
// Accepts one triangle (three vertices of signed 16-bit coordinates) per
// cycle while nothing stalls and returns its unit face normal as three
// signed Q1.15 components, truncated toward zero and clamped to +/-32767,
// with a degenerate flag in tuser when the cross product is zero (the
// components are then zero). Sustained rate is one triangle per clock when
// the sink takes every result, set by the fully pipelined front part (edges,
// cross product, range reduction, sum of squares) and back part (31-stage
// square root, 16-stage three-lane divider). A two-entry queue separates
// the parts so the front keeps accepting, until the queue is full, while
// the back holds a result that the sink has not taken. No reset sweep.
module triangle_unit_normal_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (16 bits each)
  input  logic [143:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // normal_x, normal_y, normal_z (16 bits each)
  output logic [47:0]  m_tdata_o,
  // degenerate
  output logic [0:0]   m_tuser_o
);

  logic               f_valid, f_ready, b_valid, b_ready;
  tun_pkg::tun_item_t f_item, b_item;

  // Front part.
  tun_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_data_i   (s_tdata_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  // Queue between the parts.
  tun_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_item_o  (b_item)
  );

  // Back part.
  tun_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_item_i   (b_item),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_norm_o  (m_tdata_o),
    .out_deg_o   (m_tuser_o[0])
  );

endmodule

@@ tb/triangle_unit_normal_unit_tb.sv @@
// Testbench for the triangle unit normal engine: drives triangles over the
// input stream and checks each normal against a built-in predictor.
// Depends on triangle_unit_normal_unit.
`timescale 1ns / 100ps

// Holds expected normals in request order and checks results against them.
class normal_scoreboard;
  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        deg;
  } normal_t;

  normal_t pending_q[$];
  int      n_bad;
  int      n_checked;
  int      n_degenerate;

  function new();
    n_bad = 0;
    n_checked = 0;
    n_degenerate = 0;
  endfunction

  // Integer square root, floor.
  static function longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Works out the unit normal of one triangle and queues it.
  function void note_triangle(logic [143:0] tri_data);
    longint p0[3];
    longint p1[3];
    longint p2[3];
    longint u[3];
    longint w[3];
    longint c[3];
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned r;
    longint unsigned q;
    int sh;
    logic [15:0] comp[3];
    normal_t n;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'($signed(tri_data[16*i +: 16]));
      p1[i] = longint'($signed(tri_data[16*(3+i) +: 16]));
      p2[i] = longint'($signed(tri_data[16*(6+i) +: 16]));
      u[i] = p1[i] - p0[i];
      w[i] = p2[i] - p0[i];
    end
    c[0] = u[1] * w[2] - u[2] * w[1];
    c[1] = u[2] * w[0] - u[0] * w[2];
    c[2] = u[0] * w[1] - u[1] * w[0];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      n = '{nx: 16'd0, ny: 16'd0, nz: 16'd0, deg: 1'b1};
      pending_q.push_back(n);
      return;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= sh;
      sq += m[i] * m[i];
    end
    r = root_floor(sq);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd32768) / r;
      if (q > 64'd32767) q = 64'd32767;
      if (c[i] < 0) q = -q;
      comp[i] = q[15:0];
    end
    n = '{nx: comp[0], ny: comp[1], nz: comp[2], deg: 1'b0};
    pending_q.push_back(n);
  endfunction

  // Compares one result with the oldest expected normal.
  function void check_normal(logic [47:0] data, logic deg);
    normal_t exp_n;
    normal_t got;
    got = {data[15:0], data[31:16], data[47:32], deg};
    if (pending_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("unexpected result %h deg %b", data, deg);
      return;
    end
    exp_n = pending_q.pop_front();
    n_checked++;
    if (exp_n.deg) n_degenerate++;
    if (got !== exp_n) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch #%0d: exp x %0d y %0d z %0d deg %b, got x %0d y %0d z %0d deg %b",
                 n_checked, $signed(exp_n.nx), $signed(exp_n.ny), $signed(exp_n.nz),
                 exp_n.deg, $signed(got.nx), $signed(got.ny), $signed(got.nz), got.deg);
    end
  endfunction
endclass

module triangle_unit_normal_unit_tb;
  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [143:0] s_tdata_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [47:0]  m_tdata_o;
  logic [0:0]   m_tuser_o;

  normal_scoreboard normals;
  bit               sender_done;
  int               n_sent;

  triangle_unit_normal_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Free-running 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random coordinate with a bias toward the extremes and small values.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one triangle and holds it until it is taken.
  task automatic send_triangle(logic [143:0] tri_data);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= tri_data;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    normals.note_triangle(tri_data);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [143:0] pack_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                            int d0, int d1, int d2);
    return {16'(d2), 16'(d1), 16'(d0), 16'(b2), 16'(b1), 16'(b0),
            16'(a2), 16'(a1), 16'(a0)};
  endfunction

  // Stimulus: directed corners, then random triangles.
  initial begin
    logic [143:0] t;
    normals     = new();
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    n_sent      = 0;
    sender_done = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Axis-aligned faces give a full-scale component.
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    // Degenerate: repeated vertices, collinear points, all zero.
    send_triangle('0);
    send_triangle({9{16'h7fff}});
    send_triangle(pack_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    send_triangle({9{16'h8000}});
    // Largest edges in opposite directions.
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768));
    send_triangle(pack_tri(32767, 32767, 32767, -32768, 32767, 32767,
                           32767, -32768, 32767));
    send_triangle(pack_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                           32767, 32767, -32768));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                           -32768, 32767, 32767));
    send_triangle(pack_tri(0, 0, 0, 1, 1, 1, 1, -1, 0));
    send_triangle({16'hffff, 16'h8000, 16'h7fff, 16'h0001, 16'h5555,
                   16'haaaa, 16'h0000, 16'hffff, 16'h1234});

    // Let everything drain before the random part.
    s_tvalid_i <= 1'b0;
    while (normals.pending_q.size() != 0) @(negedge clk_i);

    for (int k = 0; k < 950; k++) begin
      if (k == 400) begin
        s_tvalid_i <= 1'b0;
        while (normals.pending_q.size() != 0) @(negedge clk_i);
      end
      case ($urandom_range(0, 9))
        0: begin
          // Collinear points: v2 = v0 + 2*(v1 - v0).
          int a[3];
          int e[3];
          for (int i = 0; i < 3; i++) begin
            a[i] = $urandom_range(0, 2000) - 1000;
            e[i] = $urandom_range(0, 200) - 100;
          end
          t = pack_tri(a[0], a[1], a[2], a[0] + e[0], a[1] + e[1], a[2] + e[2],
                       a[0] + 2 * e[0], a[1] + 2 * e[1], a[2] + 2 * e[2]);
        end
        1: t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        default: begin
          for (int i = 0; i < 9; i++) t[16*i +: 16] = rand_coord();
        end
      endcase
      send_triangle(t);
    end
    s_tvalid_i  <= 1'b0;
    sender_done = 1;
  end

  // Result side: random back-pressure, check on every accepted result.
  initial begin
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_tready_i <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) normals.check_normal(m_tdata_o, m_tuser_o[0]);
  end

  // Wait for the drain, allow for the pipeline depth, then report.
  initial begin
    wait (sender_done);
    while (normals.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
             n_sent, normals.n_checked, normals.n_degenerate);
    if (normals.n_bad == 0) begin
      $display("[triangle_unit_normal_unit] OK");
    end else begin
      $display("%0d mismatches", normals.n_bad);
      $display("[triangle_unit_normal_unit] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("[triangle_unit_normal_unit] ERROR");
    $finish;
  end
endmodule
